// ===== hdl/rgt_pkg.sv =====
// ============================================================================
// rgt_pkg
// Shared constants for the range grid triangulator: configuration register
// indexes and widths, row limit and the vertex slot codes of the emitter.
// ============================================================================
package rgt_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'b1;

    localparam int AW_W = 11;   // active_width register
    localparam int AH_W = 13;   // active_height register

    localparam logic [AW_W-1:0] AW_RESET = 11'd1024;
    localparam logic [AH_W-1:0] AH_RESET = 13'd1024;

    // Row counting
    localparam int              ROW_W     = 12;
    localparam logic [AH_W-1:0] ROW_LIMIT = 13'd4096;

    // Vertex slots: triangle A is TL, BL, TR; triangle B is BL, BR, TR
    typedef logic [2:0] t_slot;

    localparam t_slot SLOT_A_TL = 3'd0;
    localparam t_slot SLOT_A_BL = 3'd1;
    localparam t_slot SLOT_A_TR = 3'd2;
    localparam t_slot SLOT_B_BL = 3'd3;
    localparam t_slot SLOT_B_BR = 3'd4;
    localparam t_slot SLOT_B_TR = 3'd5;

endpackage

// ===== hdl/rgt_ram.sv =====
// ============================================================================
// rgt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered output that only updates on a read enable (read-first).
// ============================================================================
module rgt_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/range_grid_triangulator_unit.sv =====
// ============================================================================
// range_grid_triangulator_unit
// Builds 2x2 windows over a raster-order range image using a line store in
// RAM and emits up to two triangles (six vertices) per arriving point.
// ============================================================================
// Path: an accepted point reads its line store entry at the accepting edge,
// waits in stage 1 until the emitter is free, then enters the emitter registers.
// Throughput: one point per cycle while the emitter is free; a point closing
// triangles holds the input until its three or six vertices have left the single
// vertex output port, one vertex a cycle while the receiver is ready.
// Reset: counters to zero, widths to 1024, window points invalid; the line
// store is not cleared and needs no clearing pass.
module range_grid_triangulator_unit
    import rgt_pkg::*;
#(
    parameter int MAX_ROW_POINTS = 1024,
    parameter int VALUE_BITS     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // point input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_coord_x,
    input  logic signed [VALUE_BITS-1:0] i_coord_y,
    input  logic signed [VALUE_BITS-1:0] i_coord_z,
    input  logic signed [VALUE_BITS-1:0] i_norm_x,
    input  logic signed [VALUE_BITS-1:0] i_norm_y,
    input  logic signed [VALUE_BITS-1:0] i_norm_z,
    input  logic                         i_point_valid,
    // vertex output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [VALUE_BITS-1:0] o_vertex_x,
    output logic signed [VALUE_BITS-1:0] o_vertex_y,
    output logic signed [VALUE_BITS-1:0] o_vertex_z,
    output logic signed [VALUE_BITS-1:0] o_normal_out_x,
    output logic signed [VALUE_BITS-1:0] o_normal_out_y,
    output logic signed [VALUE_BITS-1:0] o_normal_out_z,
    output logic                         o_last_vertex
);

    localparam int CW   = $clog2(MAX_ROW_POINTS);
    localparam int CMPW = ((CW > AW_W) ? CW : AW_W) + 1;
    localparam int PW   = 6 * VALUE_BITS + 1;

    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] cx;
        logic [VALUE_BITS-1:0] cy;
        logic [VALUE_BITS-1:0] cz;
        logic [VALUE_BITS-1:0] nx;
        logic [VALUE_BITS-1:0] ny;
        logic [VALUE_BITS-1:0] nz;
    } t_point;

    // Negation that saturates the most negative value
    function automatic logic [VALUE_BITS-1:0] neg_sat(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] r;
        if (v == {1'b1, {(VALUE_BITS-1){1'b0}}}) begin
            r = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [AW_W-1:0] r_active_width;
    logic [AH_W-1:0] r_active_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= AW_RESET;
            r_active_height <= AH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data[AW_W-1:0];
                CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data[AH_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective sizes: clamp to limits, zero acts as one
    logic [CMPW-1:0] eff_w;
    logic [AH_W-1:0] eff_h;

    always_comb begin
        if (r_active_width == '0) begin
            eff_w = CMPW'(1);
        end else if (CMPW'(r_active_width) > CMPW'(MAX_ROW_POINTS)) begin
            eff_w = CMPW'(MAX_ROW_POINTS);
        end else begin
            eff_w = CMPW'(r_active_width);
        end
        if (r_active_height == '0) begin
            eff_h = AH_W'(1);
        end else if (r_active_height > ROW_LIMIT) begin
            eff_h = ROW_LIMIT;
        end else begin
            eff_h = r_active_height;
        end
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic   r_p1_valid;
    logic   r_busy;
    t_slot  r_slot;
    logic   r_tri_a;
    logic   r_tri_b;
    logic   slot_last;
    logic   emit_free;
    logic   p1_adv;
    logic   in_xfer;

    assign slot_last  = (r_slot == (r_tri_b ? SLOT_B_TR : SLOT_A_TR));
    assign emit_free  = !r_busy || (i_out_ready && slot_last);
    assign p1_adv     = r_p1_valid && emit_free;
    assign o_in_ready = !r_p1_valid || p1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Raster counters
    // ------------------------------------------------------------------
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CMPW-1:0]  col_inc;
    logic [AH_W-1:0]  row_inc;
    logic             col_wrap;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    assign col_inc  = CMPW'(r_col) + CMPW'(1);
    assign row_inc  = AH_W'(r_row) + AH_W'(1);
    assign col_wrap = (col_inc >= eff_w);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Line store: read old entry and write the new point at the same column
    // ------------------------------------------------------------------
    t_point cur_pt;
    t_point line_rd;
    logic [PW-1:0] line_rd_raw;

    assign cur_pt = '{valid: i_point_valid,
                      cx: i_coord_x, cy: i_coord_y, cz: i_coord_z,
                      nx: i_norm_x,  ny: i_norm_y,  nz: i_norm_z};

    rgt_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ROW_POINTS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (r_col),
        .i_wdata (cur_pt),
        .i_re    (in_xfer),
        .i_raddr (r_col),
        .o_rdata (line_rd_raw)
    );

    assign line_rd = t_point'(line_rd_raw);

    // ------------------------------------------------------------------
    // Stage 1: point waits for its line store data
    // ------------------------------------------------------------------
    t_point r_p1_pt;
    logic   r_p1_exam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_p1_valid <= 1'b1;
        end else if (p1_adv) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_p1_pt   <= cur_pt;
            r_p1_exam <= (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
        end
    end

    // ------------------------------------------------------------------
    // Window registers: left and above-left points
    // ------------------------------------------------------------------
    t_point r_left;
    t_point r_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_above <= '0;
        end else if (p1_adv) begin
            r_left  <= r_p1_pt;
            r_above <= line_rd;
        end
    end

    // ------------------------------------------------------------------
    // Emitter: holds the closed window and walks its vertex slots
    // ------------------------------------------------------------------
    t_point r_tl;
    t_point r_bl;
    t_point r_tr;
    t_point r_br;
    logic   tri_a;
    logic   tri_b;

    assign tri_a = r_p1_exam && r_above.valid && r_left.valid && line_rd.valid;
    assign tri_b = r_p1_exam && r_left.valid && r_p1_pt.valid && line_rd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_slot  <= SLOT_A_TL;
            r_tri_a <= 1'b0;
            r_tri_b <= 1'b0;
        end else if (p1_adv) begin
            r_busy  <= tri_a || tri_b;
            r_slot  <= tri_a ? SLOT_A_TL : SLOT_B_BL;
            r_tri_a <= tri_a;
            r_tri_b <= tri_b;
        end else if (r_busy && i_out_ready) begin
            if (slot_last) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= r_slot + t_slot'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_adv) begin
            r_tl <= r_above;
            r_bl <= r_left;
            r_tr <= line_rd;
            r_br <= r_p1_pt;
        end
    end

    // Vertex select and axis swap
    t_point sel_pt;

    always_comb begin
        case (r_slot)
            SLOT_A_TL: sel_pt = r_tl;
            SLOT_A_BL: sel_pt = r_bl;
            SLOT_A_TR: sel_pt = r_tr;
            SLOT_B_BL: sel_pt = r_bl;
            SLOT_B_BR: sel_pt = r_br;
            SLOT_B_TR: sel_pt = r_tr;
            default:   sel_pt = r_tr;
        endcase
    end

    assign o_out_valid    = r_busy;
    assign o_vertex_x     = sel_pt.cy;
    assign o_vertex_y     = neg_sat(sel_pt.cx);
    assign o_vertex_z     = sel_pt.cz;
    assign o_normal_out_x = sel_pt.ny;
    assign o_normal_out_y = neg_sat(sel_pt.nx);
    assign o_normal_out_z = sel_pt.nz;
    assign o_last_vertex  = slot_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a busy emitter always holds at least one triangle
    a_busy_has_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_tri_a || r_tri_b))
        else $error("emitter busy without a triangle");

    // slot stays inside the triangles selected
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_slot <= SLOT_B_TR) && (r_tri_a || (r_slot >= SLOT_B_BL))
                    && (r_tri_b || (r_slot <= SLOT_A_TR))))
        else $error("vertex slot outside selected triangles");

    // line store data must hold while stage 1 is stalled
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !p1_adv) |=> $stable(line_rd_raw))
        else $error("line store data lost during stall");

    // end of row returns the column counter to zero
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && col_wrap) |=> (r_col == '0))
        else $error("column counter did not wrap");

endmodule

// ===== dv/range_grid_triangulator_unit_tb.sv =====
// ============================================================================
// range_grid_triangulator_unit_tb
// Self-checking bench for the range grid triangulator. Points are streamed in
// raster order over several image geometries. A behavioural mesh predictor
// tracks its own line store, window points and row/column position, and
// queues the vertices each point should emit. Every output transfer is
// checked field by field against the oldest queued vertex.
// ============================================================================
module range_grid_triangulator_unit_tb;
    import rgt_pkg::*;

    localparam int VB             = 16;
    localparam int ROW_POINTS     = 1024;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_POINTS   = 18;

    localparam logic signed [VB-1:0] MOST_NEG = {1'b1, {(VB-1){1'b0}}};
    localparam logic signed [VB-1:0] MOST_POS = {1'b0, {(VB-1){1'b1}}};

    // Directed 4x4 image: one window with both triangles, one with only the
    // upper-left triangle, one with only the lower-right, one with none
    localparam logic [15:0] MESH_MASK = 16'hE6D0;

    typedef struct packed {
        logic signed [VB-1:0] cx;
        logic signed [VB-1:0] cy;
        logic signed [VB-1:0] cz;
        logic signed [VB-1:0] nx;
        logic signed [VB-1:0] ny;
        logic signed [VB-1:0] nz;
        logic                 valid;
    } grid_point_t;

    typedef struct packed {
        logic signed [VB-1:0] vx;
        logic signed [VB-1:0] vy;
        logic signed [VB-1:0] vz;
        logic signed [VB-1:0] nox;
        logic signed [VB-1:0] noy;
        logic signed [VB-1:0] noz;
        logic                 last;
    } mesh_vertex_t;

    // DUT signals
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [VB-1:0]  i_coord_x, i_coord_y, i_coord_z;
    logic signed [VB-1:0]  i_norm_x, i_norm_y, i_norm_z;
    logic                  i_point_valid;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [VB-1:0]  o_vertex_x, o_vertex_y, o_vertex_z;
    logic signed [VB-1:0]  o_normal_out_x, o_normal_out_y, o_normal_out_z;
    logic                  o_last_vertex;

    // Mesh predictor state
    logic [AW_W-1:0] width_reg;
    logic [AH_W-1:0] height_reg;
    grid_point_t     prev_row_pts [ROW_POINTS];
    grid_point_t     west_pt;
    grid_point_t     northwest_pt;
    int unsigned     col_pos;
    int unsigned     row_pos;

    mesh_vertex_t    vertex_q [$];
    mesh_vertex_t    want;

    // Bench control and tallies
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    bit          hold_req     = 1'b0;
    int          mismatch_count = 0;
    int unsigned points_sent    = 0;
    int unsigned vertices_seen  = 0;
    int unsigned geometries     = 0;
    int unsigned quiet_cycles   = 0;

    range_grid_triangulator_unit #(
        .MAX_ROW_POINTS (ROW_POINTS),
        .VALUE_BITS     (VB)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_norm_x       (i_norm_x),
        .i_norm_y       (i_norm_y),
        .i_norm_z       (i_norm_z),
        .i_point_valid  (i_point_valid),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vertex_x     (o_vertex_x),
        .o_vertex_y     (o_vertex_y),
        .o_vertex_z     (o_vertex_z),
        .o_normal_out_x (o_normal_out_x),
        .o_normal_out_y (o_normal_out_y),
        .o_normal_out_z (o_normal_out_z),
        .o_last_vertex  (o_last_vertex)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [VB-1:0] negate_sat(input logic signed [VB-1:0] v);
        return (v == MOST_NEG) ? MOST_POS : -v;
    endfunction

    function automatic int unsigned eff_width(input int unsigned w);
        if (w > ROW_POINTS)
            return ROW_POINTS;
        return (w == 0) ? 1 : w;
    endfunction

    function automatic int unsigned eff_height(input int unsigned h);
        if (h > int'(ROW_LIMIT))
            return int'(ROW_LIMIT);
        return (h == 0) ? 1 : h;
    endfunction

    // Axis swap: x takes y, y takes negated x
    function automatic mesh_vertex_t swap_axes(input grid_point_t p);
        mesh_vertex_t v;
        v.vx   = p.cy;
        v.vy   = negate_sat(p.cx);
        v.vz   = p.cz;
        v.nox  = p.ny;
        v.noy  = negate_sat(p.nx);
        v.noz  = p.nz;
        v.last = 1'b0;
        return v;
    endfunction

    task automatic reset_predictor();
        width_reg    = AW_RESET;
        height_reg   = AH_RESET;
        west_pt      = '0;
        northwest_pt = '0;
        col_pos      = 0;
        row_pos      = 0;
        for (int i = 0; i < ROW_POINTS; i++)
            prev_row_pts[i] = '0;
    endtask

    // Queue the vertices that closing this point's window should produce,
    // then advance the window and raster position
    task automatic predict_vertices(input grid_point_t cur);
        grid_point_t  tl, tr, bl;
        mesh_vertex_t batch [6];
        mesh_vertex_t v;
        int unsigned  slot;
        int           n;
        slot = (col_pos >= ROW_POINTS) ? ROW_POINTS - 1 : col_pos;
        tl   = northwest_pt;
        tr   = prev_row_pts[slot];
        bl   = west_pt;
        n    = 0;
        if (row_pos >= 2 && col_pos >= 2) begin
            if (tl.valid && bl.valid && tr.valid) begin
                batch[0] = swap_axes(tl);
                batch[1] = swap_axes(bl);
                batch[2] = swap_axes(tr);
                n = 3;
            end
            if (bl.valid && cur.valid && tr.valid) begin
                batch[n]   = swap_axes(bl);
                batch[n+1] = swap_axes(cur);
                batch[n+2] = swap_axes(tr);
                n += 3;
            end
        end
        for (int i = 0; i < n; i++) begin
            v      = batch[i];
            v.last = (i == n - 1);
            vertex_q.push_back(v);
        end

        northwest_pt       = prev_row_pts[slot];
        prev_row_pts[slot] = cur;
        west_pt            = cur;
        if (col_pos + 1 >= eff_width(width_reg)) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= eff_height(height_reg)) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [VB-1:0] extreme_value(input int unsigned i);
        case (i % 4)
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [VB-1:0] rand_field();
        if ($urandom_range(7) == 0)
            return extreme_value($urandom_range(3));
        return VB'($urandom);
    endfunction

    function automatic grid_point_t rand_point(input int valid_pct);
        grid_point_t p;
        p.cx    = rand_field();
        p.cy    = rand_field();
        p.cz    = rand_field();
        p.nx    = rand_field();
        p.ny    = rand_field();
        p.nz    = rand_field();
        p.valid = ($urandom_range(99) < valid_pct);
        return p;
    endfunction

    // One point transfer; predicts at the accepting edge
    task automatic send_point(input grid_point_t p);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_coord_x     = p.cx;
        i_coord_y     = p.cy;
        i_coord_z     = p.cz;
        i_norm_x      = p.nx;
        i_norm_y      = p.ny;
        i_norm_z      = p.nz;
        i_point_valid = p.valid;
        do @(posedge i_clk); while (!o_in_ready);
        predict_vertices(p);
        points_sent++;
    endtask

    task automatic await_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (vertex_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Points that close no window may still be in flight after the last vertex
    task automatic await_idle();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data[CFG_DATA_W-1:0];
        if (idx == CFG_ACTIVE_WIDTH)
            width_reg = data[AW_W-1:0];
        else
            height_reg = data[AH_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Finish the current image so that the next one starts at row 0, column 0
    task automatic pad_to_image_start();
        while (col_pos != 0 || row_pos != 0)
            send_point(rand_point(75));
    endtask

    // New geometry at an image boundary; the smaller height is in force while
    // padding, and the width only changes once the raster is back at the start
    task automatic set_geometry(input int unsigned w, input int unsigned h);
        await_idle();
        if (eff_height(h) < eff_height(height_reg))
            write_reg(CFG_ACTIVE_HEIGHT, h);
        pad_to_image_start();
        await_idle();
        write_reg(CFG_ACTIVE_HEIGHT, h);
        write_reg(CFG_ACTIVE_WIDTH, w);
        geometries++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset geometry: a few points at the start of a 1024-point row
    task automatic test_reset_geometry();
        send_gap_pct = 0;
        stall_pct    = 0;
        geometries++;
        for (int i = 0; i < 8; i++)
            send_point(rand_point(100));
    endtask

    // Shrink both sizes part way along a row: the next point ends row and image
    task automatic test_resize_mid_image();
        for (int i = 0; i < 6; i++)
            send_point(rand_point(75));
        await_idle();
        write_reg(CFG_ACTIVE_WIDTH, 4);
        write_reg(CFG_ACTIVE_HEIGHT, 1);
        geometries++;
        for (int i = 0; i < 6; i++)
            send_point(rand_point(75));
    endtask

    // A 4x4 geometry with a hand-built mask and extreme field values
    task automatic test_directed_mesh();
        grid_point_t p;
        set_geometry(4, 4);
        for (int k = 0; k < 16; k++) begin
            p.cx    = extreme_value(k / 4 + k);
            p.cy    = extreme_value(k / 4 + k + 1);
            p.cz    = extreme_value(k / 4 + k + 2);
            p.nx    = extreme_value(k / 4 + k + 3);
            p.ny    = extreme_value(k / 4 + k + 4);
            p.nz    = extreme_value(k / 4 + k + 5);
            p.valid = MESH_MASK[k];
            send_point(p);
        end
    endtask

    // Zero width, width two and zero height: no window can close
    task automatic test_degenerate_sizes();
        set_geometry(0, 4);
        for (int i = 0; i < 8; i++)
            send_point(rand_point(100));
        set_geometry(2, 4);
        for (int i = 0; i < 8; i++)
            send_point(rand_point(100));
        set_geometry(4, 0);
        for (int i = 0; i < 8; i++)
            send_point(rand_point(100));
    endtask

    // Register maxima: the row runs on past any small size without a wrap,
    // then a mid-row shrink ends the row and a small image follows
    task automatic test_size_clamps();
        set_geometry((1 << AW_W) - 1, (1 << AH_W) - 1);
        for (int i = 0; i < 10; i++)
            send_point(rand_point(100));
        await_idle();
        write_reg(CFG_ACTIVE_WIDTH, 4);
        write_reg(CFG_ACTIVE_HEIGHT, 4);
        pad_to_image_start();
    endtask

    // Long receiver hold while points keep coming, then a full drain pause
    task automatic test_backpressure();
        set_geometry(4, 4);
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_req     = 1'b1;
        for (int i = 0; i < 20; i++)
            send_point(rand_point(100));
        await_results();
        for (int i = 0; i < 8; i++)
            send_point(rand_point(100));
    endtask

    // Random small images under each idling mode
    task automatic test_random_phases();
        int gap_mode   [4] = '{0, 85, 0, 20};
        int stall_mode [4] = '{0, 0, 85, 20};
        int valid_pct;
        for (int ph = 0; ph < 4; ph++) begin
            set_geometry($urandom_range(4, 6), $urandom_range(4, 5));
            send_gap_pct = gap_mode[ph];
            stall_pct    = stall_mode[ph];
            valid_pct    = $urandom_range(50, 95);
            for (int i = 0; i < PHASE_POINTS; i++)
                send_point(rand_point(valid_pct));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Vertex checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            vertices_seen++;
            if (vertex_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected vertex x=%h y=%h z=%h last=%b",
                             o_vertex_x, o_vertex_y, o_vertex_z, o_last_vertex);
            end else begin
                want = vertex_q.pop_front();
                if (o_vertex_x !== want.vx || o_vertex_y !== want.vy ||
                    o_vertex_z !== want.vz || o_normal_out_x !== want.nox ||
                    o_normal_out_y !== want.noy || o_normal_out_z !== want.noz ||
                    o_last_vertex !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("vertex %0d: want v=%h %h %h n=%h %h %h last=%b",
                                 vertices_seen, want.vx, want.vy, want.vz,
                                 want.nox, want.noy, want.noz, want.last);
                        $display("vertex %0d:  got v=%h %h %h n=%h %h %h last=%b",
                                 vertices_seen, o_vertex_x, o_vertex_y, o_vertex_z,
                                 o_normal_out_x, o_normal_out_y, o_normal_out_z,
                                 o_last_vertex);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d vertices pending",
                         WATCHDOG_LIMIT, vertex_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ACTIVE_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_coord_x     = '0;
        i_coord_y     = '0;
        i_coord_z     = '0;
        i_norm_x      = '0;
        i_norm_y      = '0;
        i_norm_z      = '0;
        i_point_valid = 1'b0;
        reset_predictor();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_geometry();
        test_resize_mid_image();
        test_directed_mesh();
        test_degenerate_sizes();
        test_size_clamps();
        test_backpressure();
        test_random_phases();

        await_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d points over %0d geometries, %0d vertices checked",
                 points_sent, geometries, vertices_seen);
        $display("idling modes: none, sender, receiver, both; long hold; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && vertex_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rgt_pkg.sv
hdl/rgt_ram.sv
hdl/range_grid_triangulator_unit.sv
dv/range_grid_triangulator_unit_tb.sv
